// ===== rtl/sqt_pkg.sv =====
// Shared types and constants for the shell quote tokenizer.
// No dependencies; every other file of the block but the two interfaces imports this package.
package sqt_pkg;

	localparam int WORD_SLOTS_DEF = 16;
	localparam logic [4:0] MAX_WORDS_RST = 5'd16;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TERM = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_SYNTAX = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BTICK = 8'h60;

	// One queue entry describes the one or two beats that a single input causes.
	typedef enum logic [2:0] {
		OP_BYTE,
		OP_TERM,
		OP_STATUS,
		OP_BS_BYTE,
		OP_TERM_STATUS
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
		logic [1:0] status;
		logic [4:0] count;
	} rec_t;

endpackage

// ===== rtl/sqt_in_if.sv =====
// Input channel of the shell quote tokenizer: one line byte or end mark per beat.
// Depends on nothing.
interface sqt_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;
	logic is_end;

	modport source (output valid, output in_char, output is_end, input ready);
	modport sink (input valid, input in_char, input is_end, output ready);
endinterface

// ===== rtl/sqt_out_if.sv =====
// Output channel of the shell quote tokenizer: one word byte, terminator or status per beat.
// Depends on nothing.
interface sqt_out_if;
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [1:0] status_code;
	logic [4:0] word_count;
	logic last_of_run;

	modport source (output valid, output out_kind, output out_byte, output status_code,
		output word_count, output last_of_run, input ready);
	modport sink (input valid, input out_kind, input out_byte, input status_code,
		input word_count, input last_of_run, output ready);
endinterface

// ===== rtl/sqt_front.sv =====
// Front end: accepts line bytes, tracks quote, escape and word state, and emits queue entries.
// Depends on sqt_pkg and sqt_in_if.
module sqt_front #(
	parameter int WORD_SLOTS = sqt_pkg::WORD_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	sqt_in_if.sink in_ch,
	input logic q_full,
	output logic push,
	output sqt_pkg::rec_t push_rec
);
	import sqt_pkg::*;

	localparam int CW = $clog2(WORD_SLOTS + 1);
	localparam int LW = (CW > 5) ? CW : 5;

	logic [4:0] max_words_q;
	logic single_open_q, double_open_q, inside_word_q, has_content_q, escape_q;
	logic [CW-1:0] words_seen_q;
	logic [1:0] line_error_q;

	logic single_open_n, double_open_n, inside_word_n, has_content_n, escape_n;
	logic [CW-1:0] words_seen_n;
	logic [1:0] line_error_n;

	logic accept, emit, go, blank, special;
	logic [LW-1:0] limit;
	logic [7:0] c;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign push = accept && emit;
	assign c = in_ch.in_char;
	assign blank = (c inside {CH_SPACE, CH_TAB});
	assign special = (c inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK});
	assign limit = (LW'(max_words_q) < LW'(WORD_SLOTS)) ? LW'(max_words_q) : LW'(WORD_SLOTS);

	always_comb begin
		single_open_n = single_open_q;
		double_open_n = double_open_q;
		inside_word_n = inside_word_q;
		has_content_n = has_content_q;
		escape_n = escape_q;
		words_seen_n = words_seen_q;
		line_error_n = line_error_q;
		emit = 1'b0;
		go = 1'b0;
		push_rec.op = OP_BYTE;
		push_rec.data = c;
		push_rec.status = ERR_NONE;
		push_rec.count = 5'd0;
		if (in_ch.is_end) begin
			emit = 1'b1;
			push_rec.op = OP_STATUS;
			push_rec.data = 8'd0;
			if (line_error_q == ERR_NONE) begin
				if (escape_q) begin
					line_error_n = ERR_SYNTAX;
				end else if (inside_word_q) begin
					if (single_open_q || double_open_q || !has_content_q) begin
						line_error_n = ERR_SYNTAX;
					end else begin
						push_rec.op = OP_TERM_STATUS;
					end
				end
			end
			push_rec.status = line_error_n;
			push_rec.count = (line_error_n == ERR_NONE) ? 5'(words_seen_q) : 5'd0;
			single_open_n = 1'b0;
			double_open_n = 1'b0;
			inside_word_n = 1'b0;
			has_content_n = 1'b0;
			escape_n = 1'b0;
			words_seen_n = '0;
			line_error_n = ERR_NONE;
		end else if (line_error_q == ERR_NONE) begin
			if (escape_q) begin
				escape_n = 1'b0;
				if (c != CH_LF) begin
					emit = 1'b1;
					has_content_n = 1'b1;
					push_rec.op = (double_open_q && !special) ? OP_BS_BYTE : OP_BYTE;
				end
			end else begin
				go = 1'b1;
				if (!inside_word_q) begin
					if (blank) begin
						go = 1'b0;
					end else if (LW'(words_seen_q) >= limit) begin
						line_error_n = ERR_TOO_MANY;
						go = 1'b0;
					end else begin
						words_seen_n = words_seen_q + 1'b1;
						inside_word_n = 1'b1;
						has_content_n = 1'b0;
						single_open_n = 1'b0;
						double_open_n = 1'b0;
					end
				end
				if (go) begin
					if (!single_open_n && !double_open_n && blank) begin
						if (!has_content_n) begin
							line_error_n = ERR_SYNTAX;
						end else begin
							emit = 1'b1;
							push_rec.op = OP_TERM;
							push_rec.data = 8'd0;
							inside_word_n = 1'b0;
						end
					end else if (!double_open_n && c == CH_SQUOTE) begin
						single_open_n = !single_open_n;
						has_content_n = 1'b1;
					end else if (!single_open_n && c == CH_DQUOTE) begin
						double_open_n = !double_open_n;
						has_content_n = 1'b1;
					end else if (!single_open_n && c == CH_BSLASH) begin
						escape_n = 1'b1;
					end else begin
						emit = 1'b1;
						has_content_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= MAX_WORDS_RST;
		end else if (cfg_we) begin
			max_words_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_open_q <= 1'b0;
			double_open_q <= 1'b0;
			inside_word_q <= 1'b0;
			has_content_q <= 1'b0;
			escape_q <= 1'b0;
			words_seen_q <= '0;
			line_error_q <= ERR_NONE;
		end else if (accept) begin
			single_open_q <= single_open_n;
			double_open_q <= double_open_n;
			inside_word_q <= inside_word_n;
			has_content_q <= has_content_n;
			escape_q <= escape_n;
			words_seen_q <= words_seen_n;
			line_error_q <= line_error_n;
		end
	end

endmodule

// ===== rtl/sqt_fifo.sv =====
// Short queue of entries between the front end and the back end.
// Depends on sqt_pkg.
module sqt_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sqt_pkg::rec_t push_rec,
	input logic pop,
	output logic full,
	output logic head_valid,
	output sqt_pkg::rec_t head_rec
);
	import sqt_pkg::*;

	rec_t mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0] cnt_q;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_rec = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sqt_back.sv =====
// Back end: expands each queue entry into one or two output beats.
// Depends on sqt_pkg and sqt_out_if.
module sqt_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input sqt_pkg::rec_t head_rec,
	output logic pop,
	sqt_out_if.source out_ch
);
	import sqt_pkg::*;

	logic phase_q;
	logic two, last, fire;

	assign two = (head_rec.op == OP_BS_BYTE) || (head_rec.op == OP_TERM_STATUS);
	assign last = !two || phase_q;
	assign fire = out_ch.valid && out_ch.ready;
	assign pop = fire && last;
	assign out_ch.valid = head_valid;
	assign out_ch.last_of_run = last;

	always_comb begin
		out_ch.out_kind = KIND_BYTE;
		out_ch.out_byte = 8'd0;
		out_ch.status_code = ERR_NONE;
		out_ch.word_count = 5'd0;
		case (head_rec.op)
			OP_BYTE: begin
				out_ch.out_byte = head_rec.data;
			end
			OP_TERM: begin
				out_ch.out_kind = KIND_TERM;
			end
			OP_STATUS: begin
				out_ch.out_kind = KIND_STATUS;
				out_ch.status_code = head_rec.status;
				out_ch.word_count = head_rec.count;
			end
			OP_BS_BYTE: begin
				out_ch.out_byte = phase_q ? head_rec.data : CH_BSLASH;
			end
			OP_TERM_STATUS: begin
				if (phase_q) begin
					out_ch.out_kind = KIND_STATUS;
					out_ch.status_code = head_rec.status;
					out_ch.word_count = head_rec.count;
				end else begin
					out_ch.out_kind = KIND_TERM;
				end
			end
			default: begin
				out_ch.out_kind = KIND_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (fire) begin
			phase_q <= !last;
		end
	end

endmodule

// ===== rtl/shell_quote_tokenizer.sv =====
// Top level of the shell quote tokenizer: front end, entry queue and back end.
// Depends on sqt_pkg, sqt_in_if, sqt_out_if, sqt_front, sqt_fifo and sqt_back.
//
// The block splits a command line, fed one byte per beat and closed by an end
// beat, into words with shell quoting and escapes, and streams word bytes,
// word terminators and one status beat per line. It takes one input beat every
// cycle while the queue is not full: the front end updates its quote and word
// state in the same cycle it accepts a byte. An input gives zero, one or two
// output beats; the back end sends one beat per cycle while the receiver is
// ready, so a burst of two-beat inputs (a literal backslash in double quotes,
// or a line end that closes a word) is absorbed by the four-entry queue, which
// holds input off once full; entries are registered there before they are sent.
module shell_quote_tokenizer #(
	parameter int WORD_SLOTS = sqt_pkg::WORD_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	sqt_in_if.sink in_ch,
	sqt_out_if.source out_ch
);
	import sqt_pkg::*;

	logic push, pop, q_full, head_valid;
	rec_t push_rec, head_rec;

	sqt_front #(
		.WORD_SLOTS(WORD_SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.q_full(q_full),
		.push(push),
		.push_rec(push_rec)
	);

	sqt_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head_rec(head_rec)
	);

	sqt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_rec(head_rec),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule

// ===== rtl/sqt_checker.sv =====
// Port-level checks for the shell quote tokenizer, bound to its top level.
// Depends on sqt_pkg and shell_quote_tokenizer.
module sqt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic [1:0] status_code,
	input logic [4:0] word_count,
	input logic last_of_run
);
	import sqt_pkg::*;

	a_plain_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_STATUS |-> status_code == ERR_NONE && word_count == 5'd0)
		else $error("status fields set on a byte or terminator beat");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_BYTE |-> out_byte == 8'd0)
		else $error("byte field set on a terminator or status beat");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |-> last_of_run)
		else $error("status beat not last of its run");

	a_term_then_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind == KIND_TERM && !last_of_run
		|=> out_valid && out_kind == KIND_STATUS)
		else $error("terminator not followed by its status beat");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

endmodule

bind shell_quote_tokenizer sqt_checker u_sqt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_kind(out_ch.out_kind),
	.out_byte(out_ch.out_byte),
	.status_code(out_ch.status_code),
	.word_count(out_ch.word_count),
	.last_of_run(out_ch.last_of_run)
);

// ===== verif/shell_quote_tokenizer_tb.sv =====
// Self-checking testbench for the shell quote tokenizer: directed lines, then random lines.
// Depends on sqt_pkg, sqt_in_if, sqt_out_if and shell_quote_tokenizer.
// A scoreboard class predicts every output beat and checks it as it is accepted.
module shell_quote_tokenizer_tb;
	import sqt_pkg::*;

	localparam int ITEM_TARGET = 1350;
	localparam int CALM_TAIL = 150;
	localparam int LONG_HOLD = 60;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] status;
		logic [4:0] count;
		logic last;
	} beat_t;

	typedef struct {
		logic [7:0] c;
		logic e;
	} line_item_t;

	class token_scoreboard;
		logic [4:0] max_words;
		bit sq_open;
		bit dq_open;
		bit in_word;
		bit has_content;
		bit esc_pending;
		logic [4:0] words_seen;
		logic [1:0] line_err;
		beat_t beats_due[$];
		beat_t step_beats[$];
		int mismatches;

		function new();
			max_words = MAX_WORDS_RST;
			mismatches = 0;
			clear_line();
		endfunction

		function void clear_line();
			sq_open = 1'b0;
			dq_open = 1'b0;
			in_word = 1'b0;
			has_content = 1'b0;
			esc_pending = 1'b0;
			words_seen = 5'd0;
			line_err = ERR_NONE;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB;
		endfunction

		function void add_beat(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
			logic [4:0] count);
			step_beats.push_back('{kind, data, status, count, 1'b0});
		endfunction

		function void word_byte(logic [7:0] c);
			if (!sq_open && !dq_open && is_blank(c)) begin
				if (!has_content) begin
					line_err = ERR_SYNTAX;
					return;
				end
				add_beat(KIND_TERM, 8'h00, ERR_NONE, 5'd0);
				in_word = 1'b0;
				return;
			end
			if (!dq_open && c == CH_SQUOTE) begin
				sq_open = !sq_open;
				has_content = 1'b1;
				return;
			end
			if (!sq_open && c == CH_DQUOTE) begin
				dq_open = !dq_open;
				has_content = 1'b1;
				return;
			end
			if (!sq_open && c == CH_BSLASH) begin
				esc_pending = 1'b1;
				return;
			end
			add_beat(KIND_BYTE, c, ERR_NONE, 5'd0);
			has_content = 1'b1;
		endfunction

		function void line_byte(logic [7:0] c);
			int lim;
			if (esc_pending) begin
				esc_pending = 1'b0;
				if (c == CH_LF)
					return;
				if (dq_open && c != CH_DQUOTE && c != CH_BSLASH && c != CH_DOLLAR
					&& c != CH_BTICK) begin
					add_beat(KIND_BYTE, CH_BSLASH, ERR_NONE, 5'd0);
					has_content = 1'b1;
					word_byte(c);
					return;
				end
				add_beat(KIND_BYTE, c, ERR_NONE, 5'd0);
				has_content = 1'b1;
				return;
			end
			if (!in_word) begin
				if (is_blank(c))
					return;
				lim = (max_words < WORD_SLOTS_DEF) ? int'(max_words) : WORD_SLOTS_DEF;
				if (int'(words_seen) >= lim) begin
					line_err = ERR_TOO_MANY;
					return;
				end
				words_seen++;
				in_word = 1'b1;
				has_content = 1'b0;
				sq_open = 1'b0;
				dq_open = 1'b0;
			end
			word_byte(c);
		endfunction

		function void line_close();
			logic [4:0] n;
			n = 5'd0;
			if (line_err == ERR_NONE) begin
				if (esc_pending) begin
					line_err = ERR_SYNTAX;
				end else if (in_word) begin
					if (sq_open || dq_open || !has_content)
						line_err = ERR_SYNTAX;
					else
						add_beat(KIND_TERM, 8'h00, ERR_NONE, 5'd0);
				end
			end
			if (line_err == ERR_NONE)
				n = words_seen;
			add_beat(KIND_STATUS, 8'h00, line_err, n);
			clear_line();
		endfunction

		function void note_input(logic [7:0] c, logic e);
			step_beats.delete();
			if (e)
				line_close();
			else if (line_err == ERR_NONE)
				line_byte(c);
			if (step_beats.size() > 0)
				step_beats[step_beats.size() - 1].last = 1'b1;
			foreach (step_beats[i])
				beats_due.push_back(step_beats[i]);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (beats_due.size() == 0) begin
				report($sformatf("unexpected beat kind=%0d byte=%02h status=%0d count=%0d last=%0b",
					got.kind, got.data, got.status, got.count, got.last));
				return;
			end
			want = beats_due.pop_front();
			if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status
				|| got.count !== want.count || got.last !== want.last)
				report($sformatf({"beat mismatch: expected kind=%0d byte=%02h status=%0d ",
					"count=%0d last=%0b, got kind=%0d byte=%02h status=%0d count=%0d last=%0b"},
					want.kind, want.data, want.status, want.count, want.last,
					got.kind, got.data, got.status, got.count, got.last));
		endfunction

		function int pending();
			return beats_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	sqt_in_if in_ch();
	sqt_out_if out_ch();

	shell_quote_tokenizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	token_scoreboard sb;
	line_item_t line_bytes[$];
	bit calm = 1'b0;
	int items_sent = 0;
	int inputs_taken = 0;
	int stall_cycles = 0;
	beat_t seen_beat;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.in_char, in_ch.is_end);
				inputs_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				seen_beat = '{out_ch.out_kind, out_ch.out_byte, out_ch.status_code,
					out_ch.word_count, out_ch.last_of_run};
				sb.check_beat(seen_beat);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// The receiver stalls in short random bursts, and once for a long stretch so that
	// the block fills up and holds its input off.
	initial begin
		bit long_hold_done;
		long_hold_done = 1'b0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && inputs_taken >= 400) begin
				long_hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_char(input logic [7:0] c);
		line_bytes.push_back('{c, 1'b0});
	endtask

	task automatic push_end();
		line_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endtask

	task automatic push_blanks();
		repeat ($urandom_range(1, 2))
			push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE
			|| c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [7:0] escape_target();
		case ($urandom_range(0, 5))
		0: return CH_DQUOTE;
		1: return CH_BSLASH;
		2: return CH_DOLLAR;
		3: return CH_BTICK;
		4: return CH_LF;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_word();
		logic [7:0] c;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 3))
			0: repeat ($urandom_range(1, 3)) push_char(plain_char());
			1: begin
				push_char(CH_SQUOTE);
				repeat ($urandom_range(0, 3)) begin
					do c = 8'($urandom_range(0, 255));
					while (c == CH_SQUOTE);
					push_char(c);
				end
				push_char(CH_SQUOTE);
			end
			2: begin
				push_char(CH_DQUOTE);
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 2) == 0) begin
						push_char(CH_BSLASH);
						push_char(escape_target());
					end else begin
						do c = 8'($urandom_range(0, 255));
						while (c == CH_DQUOTE || c == CH_BSLASH);
						push_char(c);
					end
				end
				push_char(CH_DQUOTE);
			end
			default: begin
				push_char(CH_BSLASH);
				push_char(escape_target());
			end
			endcase
		end
	endtask

	// Mostly well-formed lines with random words; a few end broken or are pure noise.
	task automatic build_line(input int lim);
		int words;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				line_bytes.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0});
			push_end();
			return;
		end
		words = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, lim + 1);
		if ($urandom_range(0, 3) == 0)
			push_blanks();
		for (int w = 0; w < words; w++) begin
			if (w > 0)
				push_blanks();
			build_word();
		end
		case ($urandom_range(0, 11))
		0: push_char(CH_BSLASH);
		1: begin
			push_char($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
			push_char(plain_char());
		end
		2: begin
			push_blanks();
			push_char(CH_BSLASH);
			push_char(CH_LF);
		end
		3: begin
			push_blanks();
			push_char(CH_BSLASH);
			push_char(CH_LF);
			push_blanks();
			build_word();
		end
		default: if ($urandom_range(0, 1) == 0) push_blanks();
		endcase
		push_end();
	endtask

	task automatic feed_line_bytes();
		line_item_t it;
		while (line_bytes.size() > 0) begin
			it = line_bytes.pop_front();
			if (!calm && $urandom_range(0, 7) == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.in_char <= it.c;
			in_ch.is_end <= it.e;
			do @(posedge clk);
			while (in_ch.ready !== 1'b1);
			@(negedge clk);
			items_sent++;
			if (items_sent >= ITEM_TARGET - CALM_TAIL)
				calm = 1'b1;
		end
	endtask

	// The register is only written once every expected beat has left the block.
	task automatic set_word_limit(input logic [4:0] v);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.max_words = v;
	endtask

	initial begin
		logic [4:0] phase_limits[12] = '{5'd16, 5'd0, 5'd1, 5'd3, 5'd16, 5'd7, 5'd2, 5'd16,
			5'd0, 5'd10, 5'd5, 5'd16};
		logic [4:0] lim;
		int phase;
		int phase_start;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 5'd0;
		in_ch.valid = 1'b0;
		in_ch.in_char = 8'h00;
		in_ch.is_end = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		push_char(8'h00);
		push_char(8'hFF);
		push_char(CH_SPACE);
		push_char(CH_DQUOTE);
		push_char(CH_BSLASH);
		push_char(8'h78);
		push_char(CH_DQUOTE);
		push_end();
		push_char(CH_BSLASH);
		push_char(CH_LF);
		push_char(CH_TAB);
		push_char(8'h7A);
		push_end();
		push_char(CH_SQUOTE);
		push_char(8'h61);
		push_end();
		push_char(8'h62);
		push_char(CH_BSLASH);
		push_end();
		push_char(CH_BSLASH);
		push_char(CH_LF);
		push_end();
		feed_line_bytes();
		set_word_limit(5'd1);
		push_char(8'h61);
		push_char(CH_SPACE);
		push_char(8'h62);
		push_end();
		feed_line_bytes();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			lim = (phase < 12) ? phase_limits[phase] : 5'($urandom_range(0, 16));
			set_word_limit(lim);
			phase_start = items_sent;
			while (items_sent - phase_start < 100 && items_sent < ITEM_TARGET) begin
				build_line(int'(lim));
				feed_line_bytes();
			end
			phase++;
		end

		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/sqt_pkg.sv
rtl/sqt_in_if.sv
rtl/sqt_out_if.sv
rtl/sqt_front.sv
rtl/sqt_fifo.sv
rtl/sqt_back.sv
rtl/shell_quote_tokenizer.sv
rtl/sqt_checker.sv
verif/shell_quote_tokenizer_tb.sv
